[src/grid_path_counter_top_macros.svh]
// assertion macros shared by the grid path counter checker
`ifndef GRID_PATH_COUNTER_TOP_MACROS_SVH
`define GRID_PATH_COUNTER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define GPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpc check failed");

// next-cycle implication, sampled on clk, off during rst
`define GPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpc check failed");

`endif

[src/gpc_pkg.sv]
// types and constants for the grid path counter
package gpc_pkg;

  // width of the path count field
  localparam int COUNT_W = 32;

  typedef struct packed {
    logic [7:0] rows;
    logic [7:0] cols;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] path_count;
    logic               overflow;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic fill;
    logic issue;
    logic out_load;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic req_empty;
    logic fill_last;
    logic one_line;
    logic run_last;
    logic out_free;
  } dp_stat_t;

endpackage

[src/grid_path_counter_top.sv]
// Grid path counter top: one request in, one saturated path count out, one request at a time.
// Steps per request: an empty grid goes straight to the result load, a single row or column
// fills the row store first, else the first-row fill is followed by a row sweep and a drain.
// One cell per cycle through one adder; a new request is taken the cycle after the result
// loads; a held output register stalls the load.
// Synchronous active-high rst clears the controller and valid flags, not the row store.
module grid_path_counter_top #(
  parameter int MAX_DIM = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gpc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gpc_pkg::rsp_t rsp
);

  gpc_pkg::ctl_cmd_t cmd;
  gpc_pkg::dp_stat_t stat;

  // sequencer
  gpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // row-buffer datapath
  gpc_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[src/gpc_ram.sv]
// generic simple dual-port ram with registered read
module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/gpc_ctrl.sv]
// controller state machine for the grid path counter
module gpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  gpc_pkg::dp_stat_t stat,
  output gpc_pkg::ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FILL  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.req_empty ? ST_DONE : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) begin
          state_next = stat.one_line ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.run_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/gpc_datapath.sv]
// row-buffer datapath: counters, row store, saturating adder, result register
module gpc_datapath #(
  parameter int MAX_DIM = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  gpc_pkg::req_t     req,
  input  gpc_pkg::ctl_cmd_t cmd,
  output gpc_pkg::dp_stat_t stat,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output gpc_pkg::rsp_t     rsp
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > 8) ? DIM_W : 8;
  localparam int CW    = gpc_pkg::COUNT_W;

  logic [DIM_W-1:0] rows_q;
  logic [DIM_W-1:0] cols_q;
  logic [DIM_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] col_end;
  logic [IDX_W-1:0] wr_col;
  logic             stage_valid;
  logic             fwd;
  logic [CW-1:0]    fwd_data;
  logic [CW-1:0]    left;
  logic [CW-1:0]    result;
  logic             ovf;

  logic [CMP_W-1:0] rows_ext;
  logic [CMP_W-1:0] cols_ext;
  logic [DIM_W-1:0] rows_cl;
  logic [DIM_W-1:0] cols_cl;

  logic [CW-1:0]    rd_data;
  logic [CW-1:0]    above;
  logic [CW:0]      sum_w;
  logic [CW-1:0]    sat;
  logic             carry;
  logic             col_last;
  logic             row_last;
  logic             wr_last;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [CW-1:0]    ram_wdata;

  // clamp incoming dimensions to the store depth
  assign rows_ext = CMP_W'(req.rows);
  assign cols_ext = CMP_W'(req.cols);
  assign rows_cl  = (rows_ext > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_ext);
  assign cols_cl  = (cols_ext > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_ext);

  // last column index of the current grid
  assign col_end  = IDX_W'(cols_q - DIM_W'(1));
  assign col_last = (col == col_end);
  assign row_last = (row == rows_q - DIM_W'(1));
  assign wr_last  = (wr_col == col_end);

  // saturating add of cell above and cell to the left
  assign above = fwd ? fwd_data : rd_data;
  assign sum_w = {1'b0, left} + {1'b0, above};
  assign carry = sum_w[CW];
  assign sat   = carry ? {CW{1'b1}} : sum_w[CW-1:0];

  // status to controller
  assign stat.req_empty = (req.rows == 8'd0) || (req.cols == 8'd0);
  assign stat.fill_last = col_last;
  assign stat.one_line  = (rows_q == DIM_W'(1)) || (cols_q == DIM_W'(1));
  assign stat.run_last  = col_last && row_last;
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // row store write port: ones during fill, sums during the sweep
  assign ram_we    = cmd.fill || stage_valid;
  assign ram_waddr = cmd.fill ? col : wr_col;
  assign ram_wdata = cmd.fill ? CW'(1) : sat;

  gpc_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_DIM)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (col),
    .rd_data (rd_data)
  );

  // dimension, index and row counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rows_q <= rows_cl;
      cols_q <= cols_cl;
      col    <= '0;
      row    <= DIM_W'(1);
    end else if (cmd.fill) begin
      col <= col_last ? IDX_W'(1) : col + IDX_W'(1);
    end else if (cmd.issue) begin
      if (col_last) begin
        col <= IDX_W'(1);
        row <= row + DIM_W'(1);
      end else begin
        col <= col + IDX_W'(1);
      end
    end
  end

  // write stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= cmd.issue;
    end
  end

  // write stage payload and forwarding of a same-address write
  always_ff @(posedge clk) begin
    wr_col   <= col;
    fwd      <= stage_valid && (wr_col == col);
    fwd_data <= sat;
  end

  // left neighbor, running result and overflow flag
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left   <= CW'(1);
      result <= stat.req_empty ? '0 : CW'(1);
      ovf    <= 1'b0;
    end else if (stage_valid) begin
      left <= wr_last ? CW'(1) : sat;
      if (wr_last) begin
        result <= sat;
      end
      if (carry) begin
        ovf <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.path_count <= result;
      rsp.overflow   <= ovf;
    end
  end

endmodule

[src/gpc_checker.sv]
// port-level checker for the grid path counter, bound to the top level
`include "grid_path_counter_top_macros.svh"

module gpc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input gpc_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input gpc_pkg::rsp_t rsp
);

  // a stalled result holds
  `GPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  // one request at a time: busy right after a transfer in
  `GPC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  // overflow only with a saturated count
  `GPC_ASSERT_NOW(a_ovf_sat, rsp_valid && rsp.overflow, rsp.path_count == {gpc_pkg::COUNT_W{1'b1}})
  // a zero count comes only from an empty grid, never with overflow
  `GPC_ASSERT_NOW(a_zero_no_ovf, rsp_valid && (rsp.path_count == '0), !rsp.overflow)

endmodule

bind grid_path_counter_top gpc_checker u_gpc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
